// File: hw/rtl/osfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osfp_pkg
// Shared types and constants of the vendor element OS fingerprint unit.
// ----------------------------------------------------------------------------
package osfp_pkg;

    localparam logic [7:0] TAG_VENDOR = 8'd221;

    localparam logic [2:0] CLS_NONE    = 3'd0;
    localparam logic [2:0] CLS_APPLE   = 3'd1;
    localparam logic [2:0] CLS_WINDOWS = 3'd2;
    localparam logic [2:0] CLS_ESP32   = 3'd3;
    localparam logic [2:0] CLS_ANDROID = 3'd4;

    localparam logic [23:0] OUI_APPLE   = 24'h0017f2;
    localparam logic [23:0] OUI_MSFT    = 24'h0050f2;
    localparam logic [7:0]  TYPE_WINDOWS = 8'h08;
    localparam logic [23:0] OUI_ESP32   = 24'h240ac4;
    localparam logic [23:0] OUI_WFA     = 24'h506f9a;

    localparam logic [2:0] HDR_BYTES = 3'd4;

    typedef enum logic [1:0] {
        PH_TAG  = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] os_class;
    } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/vendor_ie_os_fingerprint_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vendor_ie_os_fingerprint_unit
// OS class of one probe request from its vendor-specific elements.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | ie_byte[7:0], last_byte
//  out     | output    | out_valid / out_stall | os_class[2:0]
//
//  One byte a cycle unless in_stall; the class of the last byte is registered.
//  The parser state update is the only path per byte; the output register
//  and a one-word skid register hold results under a stalled output.
//  in_stall rises only while the skid register is full.
//  Reset clears the parser to expect a tag byte with no guess.
// ----------------------------------------------------------------------------
module vendor_ie_os_fingerprint_unit import osfp_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] ie_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      os_class
);

    result_t    result;
    logic       fire;
    logic       out_take;

    logic       out_valid_reg;
    logic [2:0] out_class_reg;
    logic       skid_valid_reg;
    logic [2:0] skid_class_reg;

    assign in_stall = skid_valid_reg;
    assign fire     = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    osfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .ie_byte   (ie_byte),
        .last_byte (last_byte),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_class_reg <= skid_class_reg;
            end
        end
        else if (result.valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_class_reg <= result.os_class;
            end
            else
            begin
                out_class_reg <= result.os_class;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign os_class  = out_class_reg;

endmodule
`default_nettype wire

// File: hw/rtl/osfp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osfp_parser
// Walks tag-length-value elements one byte a cycle, when fire is high,
// and judges vendor elements; reports the class on the last byte of a stream.
// ----------------------------------------------------------------------------
module osfp_parser import osfp_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic [7:0] ie_byte,
    input  wire logic       last_byte,
    output result_t         result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  remain_reg, remain_next;
    logic [2:0]  index_reg, index_next;
    logic [31:0] header_reg, header_next;
    logic [2:0]  guess_reg, guess_next;
    logic        decided_reg, decided_next;

    logic [7:0]  remain_dec;

    assign remain_dec = remain_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        remain_next  = remain_reg;
        index_next   = index_reg;
        header_next  = header_reg;
        guess_next   = guess_reg;
        decided_next = decided_reg;

        if (!decided_reg)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    len_next = ie_byte;
                    if (ie_byte == 8'd0)
                    begin
                        phase_next = PH_TAG;
                    end
                    else
                    begin
                        remain_next = ie_byte;
                        index_next  = 3'd0;
                        header_next = 32'd0;
                        phase_next  = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (index_reg < HDR_BYTES)
                    begin
                        header_next = {header_reg[23:0], ie_byte};
                        index_next  = index_reg + 3'd1;
                    end
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0)
                    begin
                        phase_next = PH_TAG;
                        // judge on the header of the first four data bytes
                        if (tag_reg == TAG_VENDOR && len_reg >= 8'd4)
                        begin
                            if (header_next[31:8] == OUI_APPLE)
                            begin
                                guess_next   = CLS_APPLE;
                                decided_next = 1'b1;
                            end
                            else if (header_next[31:8] == OUI_MSFT
                                     && header_next[7:0] == TYPE_WINDOWS)
                            begin
                                guess_next   = CLS_WINDOWS;
                                decided_next = 1'b1;
                            end
                            else if (header_next[31:8] == OUI_ESP32)
                            begin
                                guess_next   = CLS_ESP32;
                                decided_next = 1'b1;
                            end
                            else if (header_next[31:8] == OUI_WFA
                                     && guess_reg == CLS_NONE)
                            begin
                                guess_next = CLS_ANDROID;
                            end
                        end
                    end
                end
                default:
                begin
                    tag_next   = ie_byte;
                    phase_next = PH_LEN;
                end
            endcase
        end

        result.valid    = fire && last_byte;
        result.os_class = guess_next;

        // clear for the next stream
        if (last_byte)
        begin
            phase_next   = PH_TAG;
            tag_next     = 8'd0;
            len_next     = 8'd0;
            remain_next  = 8'd0;
            index_next   = 3'd0;
            header_next  = 32'd0;
            guess_next   = CLS_NONE;
            decided_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            tag_reg     <= 8'd0;
            len_reg     <= 8'd0;
            remain_reg  <= 8'd0;
            index_reg   <= 3'd0;
            header_reg  <= 32'd0;
            guess_reg   <= CLS_NONE;
            decided_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            remain_reg  <= remain_next;
            index_reg   <= index_next;
            header_reg  <= header_next;
            guess_reg   <= guess_next;
            decided_reg <= decided_next;
        end
    end

endmodule
`default_nettype wire
